@@ design/lru_page_replacement_assert.svh @@
// assertion macros used by the lru page replacement controller
`ifndef LRU_PAGE_REPLACEMENT_ASSERT_SVH
`define LRU_PAGE_REPLACEMENT_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define LRUPR_AST_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lru page replacement assertion failed");
// next-cycle implication
`define LRUPR_AST_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lru page replacement assertion failed");
`else
`define LRUPR_AST_IMP(lbl, clk, rst_n, ante, cons)
`define LRUPR_AST_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ design/lrupr_pkg.sv @@
// shared constants, types and states of the lru page replacement block
`default_nettype none
package lrupr_pkg;
	localparam int FRAMES  = 16;
	localparam int IDX_W   = 4;
	localparam int CNT_W   = 5;
	localparam int CFG_W   = 5;
	localparam int PAGE_W  = 8;
	localparam int COUNT_W = 16;

	localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;
	localparam logic [IDX_W-1:0] RANK_MAX  = IDX_W'(FRAMES - 1);

	// search beat walking down the cell chain
	typedef struct packed {
		logic              valid;
		logic [PAGE_W-1:0] page;
		logic              found;
		logic [IDX_W-1:0]  hit_idx;
		logic [IDX_W-1:0]  hit_rank;
		logic              best_set;
		logic [IDX_W-1:0]  best_rank;
		logic [IDX_W-1:0]  best_idx;
		logic [PAGE_W-1:0] best_page;
	} tok_t;

	// frame counts that bound the search
	typedef struct packed {
		logic [CNT_W-1:0] active;
		logic [CNT_W-1:0] n;
	} scope_t;

	// update broadcast to every cell
	typedef struct packed {
		logic              valid;
		logic              write;
		logic [IDX_W-1:0]  idx;
		logic [PAGE_W-1:0] page;
		logic [CNT_W-1:0]  count;
		logic [CNT_W-1:0]  limit;
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_COMMIT
	} state_t;
endpackage
`default_nettype wire

@@ design/lrupr_if.sv @@
// valid/ready channels for page references and replacement results
`default_nettype none
interface lrupr_in_if;
	import lrupr_pkg::*;
	logic              valid;
	logic              ready;
	logic [PAGE_W-1:0] page;
	modport source (output valid, output page, input ready);
	modport sink (input valid, input page, output ready);
endinterface

interface lrupr_out_if;
	import lrupr_pkg::*;
	logic               valid;
	logic               ready;
	logic               hit;
	logic [IDX_W-1:0]   frame_index;
	logic               evicted_valid;
	logic [PAGE_W-1:0]  evicted_page;
	logic [COUNT_W-1:0] fault_total;
	modport source (output valid, output hit, output frame_index, output evicted_valid,
		output evicted_page, output fault_total, input ready);
	modport sink (input valid, input hit, input frame_index, input evicted_valid,
		input evicted_page, input fault_total, output ready);
endinterface
`default_nettype wire

@@ design/lrupr_cell.sv @@
// one frame: resident page, recency rank and one stage of the search chain
`default_nettype none
module lrupr_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [lrupr_pkg::IDX_W-1:0] idx,
	input  lrupr_pkg::scope_t           scope,
	input  lrupr_pkg::cmd_t             cmd,
	input  lrupr_pkg::tok_t             tok_in,
	output lrupr_pkg::tok_t             tok_out
);
	import lrupr_pkg::*;

	logic [PAGE_W-1:0] page_q;
	logic [IDX_W-1:0]  rank_q;
	tok_t              tok_q;
	tok_t              tok_d;
	logic [CNT_W-1:0]  idx_ext;
	logic [CNT_W-1:0]  rank_ext;

	assign idx_ext  = CNT_W'(idx);
	assign rank_ext = CNT_W'(rank_q);

	always_comb begin
		tok_d = tok_in;
		// first active match wins
		if (tok_in.valid && !tok_in.found && (idx_ext < scope.active)
				&& (page_q == tok_in.page)) begin
			tok_d.found    = 1'b1;
			tok_d.hit_idx  = idx;
			tok_d.hit_rank = rank_q;
		end
		// oldest frame, lowest index on ties
		if (tok_in.valid && (idx_ext < scope.n)
				&& (!tok_in.best_set || (rank_q > tok_in.best_rank))) begin
			tok_d.best_set  = 1'b1;
			tok_d.best_rank = rank_q;
			tok_d.best_idx  = idx;
			tok_d.best_page = page_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
		end
	end

	assign tok_out = tok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q <= '0;
		end else if (cmd.valid) begin
			if (cmd.idx == idx) begin
				rank_q <= '0;
			end else if ((idx_ext < cmd.count) && (rank_ext < cmd.limit)
					&& (rank_q != RANK_MAX)) begin
				rank_q <= rank_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.write && (cmd.idx == idx)) begin
			page_q <= cmd.page;
		end
	end
endmodule
`default_nettype wire

@@ design/lrupr_ctrl.sv @@
// sequencer: takes a reference, launches the search, commits the update, holds the result
`default_nettype none
`include "lru_page_replacement_assert.svh"
module lrupr_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [lrupr_pkg::CFG_W-1:0] cfg_data,
	lrupr_in_if.sink                    page_ch,
	lrupr_out_if.source                 result_ch,
	output lrupr_pkg::tok_t             tok_launch,
	input  lrupr_pkg::tok_t             tok_last,
	output lrupr_pkg::scope_t           scope,
	output lrupr_pkg::cmd_t             cmd
);
	import lrupr_pkg::*;

	state_t             state_q;
	state_t             state_d;
	logic [CFG_W-1:0]   fiu_q;
	logic [CNT_W-1:0]   filled_q;
	logic [COUNT_W-1:0] fault_q;
	scope_t             scope_q;
	tok_t               tok0_q;
	tok_t               res_q;
	logic               out_valid_q;
	logic               hit_q;
	logic [IDX_W-1:0]   frame_q;
	logic               ev_valid_q;
	logic [PAGE_W-1:0]  ev_page_q;

	logic               in_ready;
	logic               accept;
	logic               out_free;
	logic               commit;
	logic [CNT_W-1:0]   n_c;
	logic [CNT_W-1:0]   active_c;
	logic               fill;
	logic [IDX_W-1:0]   frame_c;
	tok_t               launch_c;

	// clamp the configured frame count to 1..FRAMES
	always_comb begin
		if (fiu_q == '0) begin
			n_c = CNT_W'(1);
		end else if (fiu_q > CFG_W'(FRAMES)) begin
			n_c = CNT_W'(FRAMES);
		end else begin
			n_c = CNT_W'(fiu_q);
		end
		active_c = (filled_q < n_c) ? filled_q : n_c;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (page_ch.valid) state_d = ST_SEARCH;
			end
			ST_SEARCH: begin
				if (tok_last.valid) state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				if (!out_valid_q || result_ch.ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == ST_IDLE);
		accept   = in_ready && page_ch.valid;
		out_free = !out_valid_q || result_ch.ready;
		commit   = (state_q == ST_COMMIT) && out_free;
	end

	assign page_ch.ready = in_ready;

	always_comb begin
		launch_c       = '0;
		launch_c.valid = 1'b1;
		launch_c.page  = page_ch.page;
	end

	always_comb begin
		fill = (filled_q < scope_q.n);
		if (res_q.found) begin
			frame_c = res_q.hit_idx;
		end else if (fill) begin
			frame_c = filled_q[IDX_W-1:0];
		end else begin
			frame_c = res_q.best_idx;
		end
		cmd       = '0;
		cmd.valid = commit;
		cmd.write = !res_q.found;
		cmd.idx   = frame_c;
		cmd.page  = res_q.page;
		priority if (res_q.found) begin
			cmd.count = scope_q.active;
			cmd.limit = CNT_W'(res_q.hit_rank);
		end else if (fill) begin
			// a new frame ages every filled frame below it
			cmd.count = filled_q;
			cmd.limit = CNT_W'(FRAMES);
		end else begin
			cmd.count = scope_q.n;
			cmd.limit = CNT_W'(res_q.best_rank);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fiu_q       <= CFG_RESET;
			filled_q    <= '0;
			fault_q     <= '0;
			scope_q     <= '0;
			tok0_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) fiu_q <= cfg_data;
			tok0_q <= accept ? launch_c : '0;
			if (accept) begin
				scope_q.n      <= n_c;
				scope_q.active <= active_c;
			end
			if (commit && !res_q.found) begin
				if (fault_q != '1) fault_q <= fault_q + 1'b1;
				if (fill) filled_q <= filled_q + 1'b1;
			end
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (result_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_SEARCH) && tok_last.valid) res_q <= tok_last;
		if (commit) begin
			hit_q      <= res_q.found;
			frame_q    <= frame_c;
			ev_valid_q <= !res_q.found && !fill;
			ev_page_q  <= (!res_q.found && !fill) ? res_q.best_page : '0;
		end
	end

	assign tok_launch              = tok0_q;
	assign scope                   = scope_q;
	assign result_ch.valid         = out_valid_q;
	assign result_ch.hit           = hit_q;
	assign result_ch.frame_index   = frame_q;
	assign result_ch.evicted_valid = ev_valid_q;
	assign result_ch.evicted_page  = ev_page_q;
	assign result_ch.fault_total   = fault_q;

	`LRUPR_AST_NXT(a_accept_search, clk, arst_n, accept, state_q == ST_SEARCH)
	`LRUPR_AST_IMP(a_last_in_search, clk, arst_n, tok_last.valid, state_q == ST_SEARCH)
	`LRUPR_AST_NXT(a_commit_shows, clk, arst_n, commit, out_valid_q)
	`LRUPR_AST_IMP(a_filled_bound, clk, arst_n, 1'b1, filled_q <= CNT_W'(FRAMES))
endmodule
`default_nettype wire

@@ design/lru_page_replacement.sv @@
// top level of the lru page replacement block
// Least-recently-used page replacement over up to 16 frames (frames_in_use, reset 16,
// zero acts as one, values above 16 act as 16). References are handled one at a time:
// a search beat walks the row of 16 frame cells one cell per cycle, comparing the page
// and tracking the oldest frame, then the outcome is captured and the commit applies
// the rank and page update to all cells and loads the result register. The next
// reference is taken while a result still waits on the output; a stalled output holds
// the commit until the result register frees up. No clearing pass is needed after
// reset. Write frames_in_use only while the block is idle.
`default_nettype none
module lru_page_replacement (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [lrupr_pkg::CFG_W-1:0] cfg_data,
	lrupr_in_if.sink                    page_ch,
	lrupr_out_if.source                 result_ch
);
	import lrupr_pkg::*;

	tok_t   tok [FRAMES+1];
	scope_t scope;
	cmd_t   cmd;

	lrupr_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.page_ch    (page_ch),
		.result_ch  (result_ch),
		.tok_launch (tok[0]),
		.tok_last   (tok[FRAMES]),
		.scope      (scope),
		.cmd        (cmd)
	);

	for (genvar i = 0; i < FRAMES; i++) begin : g_cell
		lrupr_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.idx     (IDX_W'(i)),
			.scope   (scope),
			.cmd     (cmd),
			.tok_in  (tok[i]),
			.tok_out (tok[i+1])
		);
	end
endmodule
`default_nettype wire
